/* hdl/lrla_pkg.sv */
// Shared types, constants and the control store of the rest length actuator.
package lrla_pkg;

   localparam int LenW            = 31;
   localparam int DtW             = 17;
   localparam int FracW           = 16;
   localparam int VelW            = 32;
   localparam int DivW            = 48;
   localparam int DivDenW         = 31;
   localparam int DivBitsPerCycle = 2;
   localparam int DivSteps        = DivW / DivBitsPerCycle;
   localparam int DivCntW         = $clog2(DivSteps);
   localparam int PcW             = 5;
   localparam int CsrAddrW        = 5;
   localparam int CsrDataW        = 32;

   localparam logic OP_MOVE = 1'b0;
   localparam logic OP_TICK = 1'b1;

   localparam logic [LenW-1:0] RestLengthMax = {LenW{1'b1}};
   localparam logic [VelW-1:0] VelocityMax   = {1'b0, {(VelW-1){1'b1}}};
   localparam logic [VelW-1:0] VelocityMin   = {1'b1, {(VelW-1){1'b0}}};

   // Register reset values.
   localparam logic [LenW-1:0] TargetVelocityReset    = 31'd65536;
   localparam logic [LenW-1:0] MaxAccelReset          = 31'd65536;
   localparam logic [LenW-1:0] MaxTensionReset        = 31'd6553600;
   localparam logic [LenW-1:0] StiffnessReset         = 31'd65536;
   localparam logic [LenW-1:0] MinActualLengthReset   = 31'd0;
   localparam logic [LenW-1:0] MinRestLengthReset     = 31'd0;
   localparam logic [DtW-1:0]  TimeStepReset          = 17'd655;
   localparam logic [LenW-1:0] InitialRestLengthReset = 31'd65536;

   typedef enum logic [2:0] {
      CSR_TARGET_VELOCITY,
      CSR_MAX_ACCEL,
      CSR_MAX_TENSION,
      CSR_STIFFNESS,
      CSR_MIN_ACTUAL_LENGTH,
      CSR_MIN_REST_LENGTH,
      CSR_TIME_STEP,
      CSR_INITIAL_REST_LENGTH
   } csr_index_type;

   typedef struct packed {
      logic              op;
      logic signed [31:0] target_length;
      logic [LenW-1:0]   actual_length;
   } req_type;

   typedef struct packed {
      logic [LenW-1:0]    rest_length;
      logic signed [31:0] velocity;
      logic               error;
   } rsp_type;

   typedef struct packed {
      logic [LenW-1:0] target_velocity;
      logic [LenW-1:0] max_accel;
      logic [LenW-1:0] max_tension;
      logic [LenW-1:0] stiffness;
      logic [LenW-1:0] min_actual_length;
      logic [LenW-1:0] min_rest_length;
      logic [DtW-1:0]  time_step;
   } cfg_type;

   // Datapath operations, one per control word.
   typedef enum logic [4:0] {
      U_NOP,
      U_OUT_OK,
      U_OUT_ERR,
      U_MUL_STEP,
      U_MUL_VCHG,
      U_MUL_ASTEP,
      U_MUL_TEN,
      U_DIV_TEN,
      U_PREF_LOW,
      U_PREF_TGT,
      U_DIFF,
      U_BIG,
      U_DIV_DIFF,
      U_SMALL_TEST,
      U_SMALL_STEP,
      U_CLAMP,
      U_TDIFF,
      U_TICK_END
   } uop_type;

   // Sequencing: a true condition goes to dest, a false one to the next step.
   // The wait conditions hold the step until their event, then go to dest.
   typedef enum logic [3:0] {
      C_NEXT,
      C_JUMP,
      C_WAIT_REQ,
      C_WAIT_DIV,
      C_WAIT_OUT,
      C_IF_TICK,
      C_IF_NEG,
      C_IF_NO_TEN,
      C_IF_STILL,
      C_IF_SMALL
   } cond_type;

   typedef struct packed {
      uop_type        uop;
      cond_type       cond;
      logic [PcW-1:0] dest;
   } ctrl_word_type;

   typedef struct packed {
      uop_type uop;
      logic    accept;
   } ctrl_type;

   typedef struct packed {
      logic is_tick;
      logic is_neg;
      logic no_tension;
      logic no_motion;
      logic small_diff;
      logic div_busy;
      logic out_full;
   } status_type;

   localparam logic [PcW-1:0] A_IDLE       = 5'd0;
   localparam logic [PcW-1:0] A_CHK_TICK   = 5'd1;
   localparam logic [PcW-1:0] A_CHK_NEG    = 5'd2;
   localparam logic [PcW-1:0] A_MUL_STEP   = 5'd3;
   localparam logic [PcW-1:0] A_MUL_VCHG   = 5'd4;
   localparam logic [PcW-1:0] A_MUL_ASTEP  = 5'd5;
   localparam logic [PcW-1:0] A_MUL_TEN    = 5'd6;
   localparam logic [PcW-1:0] A_TEN_TEST   = 5'd7;
   localparam logic [PcW-1:0] A_DIV_TEN    = 5'd8;
   localparam logic [PcW-1:0] A_TEN_WAIT   = 5'd9;
   localparam logic [PcW-1:0] A_PREF_LOW   = 5'd10;
   localparam logic [PcW-1:0] A_PREF_TGT   = 5'd11;
   localparam logic [PcW-1:0] A_DIFF       = 5'd12;
   localparam logic [PcW-1:0] A_STILL_TEST = 5'd13;
   localparam logic [PcW-1:0] A_SIZE_TEST  = 5'd14;
   localparam logic [PcW-1:0] A_BIG        = 5'd15;
   localparam logic [PcW-1:0] A_DIV_DIFF   = 5'd16;
   localparam logic [PcW-1:0] A_DIFF_WAIT  = 5'd17;
   localparam logic [PcW-1:0] A_SMALL_TEST = 5'd18;
   localparam logic [PcW-1:0] A_SMALL_STEP = 5'd19;
   localparam logic [PcW-1:0] A_CLAMP      = 5'd20;
   localparam logic [PcW-1:0] A_OUT        = 5'd21;
   localparam logic [PcW-1:0] A_ERR        = 5'd22;
   localparam logic [PcW-1:0] A_TDIFF      = 5'd23;
   localparam logic [PcW-1:0] A_TDIV       = 5'd24;
   localparam logic [PcW-1:0] A_TWAIT      = 5'd25;
   localparam logic [PcW-1:0] A_TICK_END   = 5'd26;

   function automatic ctrl_word_type ucode_rom(input logic [PcW-1:0] pc);
      ctrl_word_type w;
      unique case (pc)
         A_IDLE:       w = '{U_NOP,        C_WAIT_REQ,  A_CHK_TICK};
         A_CHK_TICK:   w = '{U_NOP,        C_IF_TICK,   A_TDIFF};
         A_CHK_NEG:    w = '{U_NOP,        C_IF_NEG,    A_ERR};
         A_MUL_STEP:   w = '{U_MUL_STEP,   C_NEXT,      A_IDLE};
         A_MUL_VCHG:   w = '{U_MUL_VCHG,   C_NEXT,      A_IDLE};
         A_MUL_ASTEP:  w = '{U_MUL_ASTEP,  C_NEXT,      A_IDLE};
         A_MUL_TEN:    w = '{U_MUL_TEN,    C_NEXT,      A_IDLE};
         A_TEN_TEST:   w = '{U_NOP,        C_IF_NO_TEN, A_PREF_TGT};
         A_DIV_TEN:    w = '{U_DIV_TEN,    C_NEXT,      A_IDLE};
         A_TEN_WAIT:   w = '{U_NOP,        C_WAIT_DIV,  A_PREF_LOW};
         A_PREF_LOW:   w = '{U_PREF_LOW,   C_JUMP,      A_DIFF};
         A_PREF_TGT:   w = '{U_PREF_TGT,   C_NEXT,      A_IDLE};
         A_DIFF:       w = '{U_DIFF,       C_NEXT,      A_IDLE};
         A_STILL_TEST: w = '{U_NOP,        C_IF_STILL,  A_CLAMP};
         A_SIZE_TEST:  w = '{U_NOP,        C_IF_SMALL,  A_DIV_DIFF};
         A_BIG:        w = '{U_BIG,        C_JUMP,      A_CLAMP};
         A_DIV_DIFF:   w = '{U_DIV_DIFF,   C_NEXT,      A_IDLE};
         A_DIFF_WAIT:  w = '{U_NOP,        C_WAIT_DIV,  A_SMALL_TEST};
         A_SMALL_TEST: w = '{U_SMALL_TEST, C_NEXT,      A_IDLE};
         A_SMALL_STEP: w = '{U_SMALL_STEP, C_NEXT,      A_IDLE};
         A_CLAMP:      w = '{U_CLAMP,      C_NEXT,      A_IDLE};
         A_OUT:        w = '{U_OUT_OK,     C_WAIT_OUT,  A_IDLE};
         A_ERR:        w = '{U_OUT_ERR,    C_WAIT_OUT,  A_IDLE};
         A_TDIFF:      w = '{U_TDIFF,      C_NEXT,      A_IDLE};
         A_TDIV:       w = '{U_DIV_DIFF,   C_NEXT,      A_IDLE};
         A_TWAIT:      w = '{U_NOP,        C_WAIT_DIV,  A_TICK_END};
         A_TICK_END:   w = '{U_TICK_END,   C_JUMP,      A_OUT};
         default:      w = '{U_NOP,        C_JUMP,      A_IDLE};
      endcase
      return w;
   endfunction

endpackage

/* hdl/lrla_div.sv */
// Shared unsigned restoring divider, two quotient bits per cycle.
module lrla_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [lrla_pkg::DivW-1:0]      dividend,
   input  logic [lrla_pkg::DivDenW-1:0]   divisor,
   output logic                           busy,
   output logic [lrla_pkg::DivW-1:0]      quotient
);
   import lrla_pkg::*;

   logic [DivW-1:0]    quo_ff, quo_in;
   logic [DivDenW:0]   rem_ff, rem_in;
   logic [DivDenW-1:0] den_ff, den_in;
   logic [DivCntW-1:0] cnt_ff, cnt_in;
   logic               busy_ff, busy_in;

   // The dividend shifts out of the top of quo_ff while quotient bits enter below.
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         for (int i = 0; i < DivBitsPerCycle; i++) begin
            rem_in = {rem_in[DivDenW-1:0], quo_in[DivW-1]};
            quo_in = {quo_in[DivW-2:0], 1'b0};
            if (rem_in >= {1'b0, den_ff}) begin
               rem_in    = rem_in - {1'b0, den_ff};
               quo_in[0] = 1'b1;
            end
         end
         if (cnt_ff == DivCntW'(DivSteps - 1)) begin
            busy_in = 1'b0;
         end
         cnt_in = cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

/* hdl/lrla_seq.sv */
// Microcode sequencer: step counter, control store and branch logic.
module lrla_seq (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  lrla_pkg::status_type  status,
   output lrla_pkg::ctrl_type    ctrl
);
   import lrla_pkg::*;

   logic [PcW-1:0] pc_ff, pc_in;
   ctrl_word_type  word;
   logic           held;
   logic           taken;

   assign word      = ucode_rom(pc_ff);
   assign req_ready = (word.cond == C_WAIT_REQ);

   always_comb begin
      held  = 1'b0;
      taken = 1'b0;
      unique case (word.cond)
         C_NEXT:      taken = 1'b0;
         C_JUMP:      taken = 1'b1;
         C_WAIT_REQ: begin
            held  = !req_valid;
            taken = 1'b1;
         end
         C_WAIT_DIV: begin
            held  = status.div_busy;
            taken = 1'b1;
         end
         C_WAIT_OUT: begin
            held  = status.out_full;
            taken = 1'b1;
         end
         C_IF_TICK:   taken = status.is_tick;
         C_IF_NEG:    taken = status.is_neg;
         C_IF_NO_TEN: taken = status.no_tension;
         C_IF_STILL:  taken = status.no_motion;
         C_IF_SMALL:  taken = status.small_diff;
         default:     taken = 1'b0;
      endcase
   end

   always_comb begin
      if (held) begin
         pc_in = pc_ff;
      end else if (taken) begin
         pc_in = word.dest;
      end else begin
         pc_in = pc_ff + 1'b1;
      end
   end

   // A held step issues no operation, so a result load waits for a free output.
   always_comb begin
      ctrl.uop    = held ? U_NOP : word.uop;
      ctrl.accept = req_valid && req_ready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= A_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

/* hdl/lrla_dp.sv */
// Datapath: multiplier, divider, state registers and the result register.
module lrla_dp (
   input  logic                  clock,
   input  logic                  reset,
   input  lrla_pkg::ctrl_type    ctrl,
   input  lrla_pkg::req_type     req_data,
   input  lrla_pkg::cfg_type     cfg,
   output lrla_pkg::status_type  status,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output lrla_pkg::rsp_type     rsp_data
);
   import lrla_pkg::*;

   req_type            item_ff, item_in;
   logic [63:0]        prod_ff, prod_in;
   logic [31:0]        step_ff, step_in;
   logic [31:0]        vchg_ff, vchg_in;
   logic [32:0]        astep_ff, astep_in;
   logic [LenW-1:0]    pref_ff, pref_in;
   logic signed [31:0] diff_ff, diff_in;
   logic signed [34:0] r_ff, r_in;
   logic               flag_ff, flag_in;
   logic [LenW-1:0]    rest_ff, rest_in;
   logic [LenW-1:0]    last_rest_ff, last_rest_in;
   logic signed [31:0] lv_ff, lv_in;
   rsp_type            rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic [DtW-1:0]     dt_eff;
   logic [LenW-1:0]    k_eff;
   logic [LenW-1:0]    dpos;
   logic [32:0]        mul_a;
   logic [30:0]        mul_b;
   logic [63:0]        mul_p;

   logic               div_start;
   logic [DivW-1:0]    div_dividend;
   logic [DivDenW-1:0] div_divisor;
   logic               div_busy;
   logic [DivW-1:0]    quo;

   logic               diff_neg;
   logic               diff_pos;
   logic [31:0]        diff_mag;
   logic signed [34:0] rest_s;
   logic signed [33:0] stv;
   logic signed [33:0] dv;
   logic [33:0]        dv_mag;
   logic [32:0]        big_sel;
   logic signed [34:0] big_delta;
   logic signed [48:0] qs;
   logic signed [49:0] qv;
   logic [49:0]        qv_mag;
   logic signed [34:0] astep_pos;
   logic signed [34:0] astep_neg;
   logic signed [34:0] small_delta;
   logic [LenW-1:0]    clamped;
   logic [VelW-1:0]    vel_sat;

   assign dt_eff = (cfg.time_step == '0) ? DtW'(1) : cfg.time_step;
   assign k_eff  = (cfg.stiffness == '0) ? LenW'(1) : cfg.stiffness;

   // Target is known to be nonnegative on the move path.
   assign dpos = (item_ff.actual_length > item_ff.target_length[LenW-1:0]) ?
                 item_ff.actual_length - item_ff.target_length[LenW-1:0] : '0;

   always_comb begin
      case (ctrl.uop)
         U_MUL_STEP: begin
            mul_a = {2'b0, cfg.target_velocity};
            mul_b = {14'b0, dt_eff};
         end
         U_MUL_VCHG: begin
            mul_a = {2'b0, cfg.max_accel};
            mul_b = {14'b0, dt_eff};
         end
         U_MUL_ASTEP: begin
            mul_a = {1'b0, prod_ff[FracW +: 32]};
            mul_b = {14'b0, dt_eff};
         end
         default: begin
            mul_a = {2'b0, dpos};
            mul_b = k_eff;
         end
      endcase
   end

   assign mul_p = {31'b0, mul_a} * {33'b0, mul_b};

   assign div_start = (ctrl.uop == U_DIV_TEN) || (ctrl.uop == U_DIV_DIFF);

   always_comb begin
      if (ctrl.uop == U_DIV_TEN) begin
         div_dividend = {1'b0, cfg.max_tension, {FracW{1'b0}}};
         div_divisor  = k_eff;
      end else begin
         div_dividend = {1'b0, diff_mag[LenW-1:0], {FracW{1'b0}}};
         div_divisor  = {14'b0, dt_eff};
      end
   end

   lrla_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .quotient (quo)
   );

   assign diff_neg = diff_ff[31];
   assign diff_pos = !diff_ff[31] && (diff_ff != '0);
   assign diff_mag = diff_neg ? $unsigned(-diff_ff) : $unsigned(diff_ff);
   assign rest_s   = $signed({4'b0, rest_ff});

   // Large step: the velocity step, or the acceleration step when the speed
   // change against the last velocity is too big.
   assign stv     = diff_neg ? -$signed({3'b0, cfg.target_velocity})
                             : $signed({3'b0, cfg.target_velocity});
   assign dv      = stv - $signed({{2{lv_ff[31]}}, lv_ff});
   assign dv_mag  = dv[33] ? $unsigned(-dv) : $unsigned(dv);
   assign big_sel = (dv_mag > {2'b0, vchg_ff}) ? astep_ff : {1'b0, step_ff};
   assign big_delta = diff_neg ? -$signed({2'b0, big_sel}) : $signed({2'b0, big_sel});

   // Signed quotient of the difference over the control period.
   assign qs     = diff_neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
   assign qv     = $signed({qs[48], qs}) - $signed({{18{lv_ff[31]}}, lv_ff});
   assign qv_mag = qv[49] ? $unsigned(-qv) : $unsigned(qv);

   assign astep_pos = $signed({2'b0, astep_ff});
   assign astep_neg = -astep_pos;

   always_comb begin
      if (!flag_ff) begin
         small_delta = $signed({{3{diff_ff[31]}}, diff_ff});
      end else if (diff_ff != '0) begin
         small_delta = diff_neg ? astep_neg : astep_pos;
      end else if (lv_ff > 0) begin
         small_delta = astep_neg;
      end else if (lv_ff < 0) begin
         small_delta = astep_pos;
      end else begin
         small_delta = '0;
      end
   end

   always_comb begin
      if (r_ff < $signed({4'b0, cfg.min_rest_length})) begin
         clamped = cfg.min_rest_length;
      end else if (r_ff > $signed({4'b0, RestLengthMax})) begin
         clamped = RestLengthMax;
      end else begin
         clamped = r_ff[LenW-1:0];
      end
   end

   always_comb begin
      if (qs[48:31] == {18{qs[48]}}) begin
         vel_sat = qs[31:0];
      end else begin
         vel_sat = qs[48] ? VelocityMin : VelocityMax;
      end
   end

   always_comb begin
      item_in      = item_ff;
      prod_in      = prod_ff;
      step_in      = step_ff;
      vchg_in      = vchg_ff;
      astep_in     = astep_ff;
      pref_in      = pref_ff;
      diff_in      = diff_ff;
      r_in         = r_ff;
      flag_in      = flag_ff;
      rest_in      = rest_ff;
      last_rest_in = last_rest_ff;
      lv_in        = lv_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (ctrl.accept) begin
         item_in = req_data;
      end
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (ctrl.uop) inside
         U_MUL_STEP: prod_in = mul_p;
         U_MUL_VCHG: begin
            step_in = prod_ff[FracW +: 32];
            prod_in = mul_p;
         end
         U_MUL_ASTEP: begin
            vchg_in = prod_ff[FracW +: 32];
            prod_in = mul_p;
         end
         U_MUL_TEN: begin
            astep_in = prod_ff[FracW +: 33];
            prod_in  = mul_p;
         end
         U_PREF_LOW: pref_in = item_ff.actual_length - quo[LenW-1:0];
         U_PREF_TGT: pref_in = item_ff.target_length[LenW-1:0];
         U_DIFF: begin
            diff_in = $signed({1'b0, pref_ff}) - $signed({1'b0, rest_ff});
            r_in    = rest_s;
         end
         U_BIG:        r_in    = rest_s + big_delta;
         U_SMALL_TEST: flag_in = (qv_mag > {18'b0, vchg_ff});
         U_SMALL_STEP: r_in    = rest_s + small_delta;
         U_CLAMP:      rest_in = clamped;
         U_TDIFF:      diff_in = $signed({1'b0, rest_ff}) - $signed({1'b0, last_rest_ff});
         U_TICK_END: begin
            lv_in        = vel_sat;
            last_rest_in = rest_ff;
         end
         U_OUT_OK, U_OUT_ERR: begin
            rsp_in.rest_length = rest_ff;
            rsp_in.velocity    = lv_ff;
            rsp_in.error       = (ctrl.uop == U_OUT_ERR);
            rsp_valid_in       = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rest_ff      <= InitialRestLengthReset;
         last_rest_ff <= InitialRestLengthReset;
         lv_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rest_ff      <= rest_in;
         last_rest_ff <= last_rest_in;
         lv_ff        <= lv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff  <= item_in;
      prod_ff  <= prod_in;
      step_ff  <= step_in;
      vchg_ff  <= vchg_in;
      astep_ff <= astep_in;
      pref_ff  <= pref_in;
      diff_ff  <= diff_in;
      r_ff     <= r_in;
      flag_ff  <= flag_in;
      rsp_ff   <= rsp_in;
   end

   always_comb begin
      status.is_tick    = (item_ff.op == OP_TICK);
      status.is_neg     = item_ff.target_length[31];
      status.no_tension = (prod_ff <= {17'b0, cfg.max_tension, {FracW{1'b0}}});
      status.no_motion  = !(item_ff.actual_length > cfg.min_actual_length) && !diff_pos;
      status.small_diff = (diff_mag <= step_ff);
      status.div_busy   = div_busy;
      status.out_full   = rsp_valid_ff;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* hdl/limited_rest_length_actuator.sv */
// A rejected target goes straight to the error result; a move runs the multiplies and up to
// two divisions, and a tick runs one division. Each division holds the sequence while the
// shared divider is busy, at two quotient bits per cycle. One item at a time; the next is
// taken once its result is loaded. Reset is synchronous, active high: registers take their
// defaults, rest length 1.0, velocity 0.
module limited_rest_length_actuator (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  lrla_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output lrla_pkg::rsp_type               rsp_data,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [lrla_pkg::CsrAddrW-1:0]   csr_paddr,
   input  logic [lrla_pkg::CsrDataW-1:0]   csr_pwdata,
   output logic [lrla_pkg::CsrDataW-1:0]   csr_prdata,
   output logic                            csr_pready
);
   import lrla_pkg::*;

   logic [LenW-1:0] tv_ff, tv_in;
   logic [LenW-1:0] ma_ff, ma_in;
   logic [LenW-1:0] mt_ff, mt_in;
   logic [LenW-1:0] k_ff, k_in;
   logic [LenW-1:0] mal_ff, mal_in;
   logic [LenW-1:0] mrl_ff, mrl_in;
   logic [DtW-1:0]  dt_ff, dt_in;
   logic [LenW-1:0] irl_ff, irl_in;

   csr_index_type   csr_index;
   logic            csr_write;
   cfg_type         cfg;
   status_type      status;
   ctrl_type        ctrl;

   assign csr_index  = csr_index_type'(csr_paddr[CsrAddrW-1:2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      tv_in  = tv_ff;
      ma_in  = ma_ff;
      mt_in  = mt_ff;
      k_in   = k_ff;
      mal_in = mal_ff;
      mrl_in = mrl_ff;
      dt_in  = dt_ff;
      irl_in = irl_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_TARGET_VELOCITY:     tv_in  = csr_pwdata[LenW-1:0];
            CSR_MAX_ACCEL:           ma_in  = csr_pwdata[LenW-1:0];
            CSR_MAX_TENSION:         mt_in  = csr_pwdata[LenW-1:0];
            CSR_STIFFNESS:           k_in   = csr_pwdata[LenW-1:0];
            CSR_MIN_ACTUAL_LENGTH:   mal_in = csr_pwdata[LenW-1:0];
            CSR_MIN_REST_LENGTH:     mrl_in = csr_pwdata[LenW-1:0];
            CSR_TIME_STEP:           dt_in  = csr_pwdata[DtW-1:0];
            CSR_INITIAL_REST_LENGTH: irl_in = csr_pwdata[LenW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         CSR_TARGET_VELOCITY:     csr_prdata = {1'b0, tv_ff};
         CSR_MAX_ACCEL:           csr_prdata = {1'b0, ma_ff};
         CSR_MAX_TENSION:         csr_prdata = {1'b0, mt_ff};
         CSR_STIFFNESS:           csr_prdata = {1'b0, k_ff};
         CSR_MIN_ACTUAL_LENGTH:   csr_prdata = {1'b0, mal_ff};
         CSR_MIN_REST_LENGTH:     csr_prdata = {1'b0, mrl_ff};
         CSR_TIME_STEP:           csr_prdata = {15'b0, dt_ff};
         CSR_INITIAL_REST_LENGTH: csr_prdata = {1'b0, irl_ff};
         default:                 csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tv_ff  <= TargetVelocityReset;
         ma_ff  <= MaxAccelReset;
         mt_ff  <= MaxTensionReset;
         k_ff   <= StiffnessReset;
         mal_ff <= MinActualLengthReset;
         mrl_ff <= MinRestLengthReset;
         dt_ff  <= TimeStepReset;
         irl_ff <= InitialRestLengthReset;
      end else begin
         tv_ff  <= tv_in;
         ma_ff  <= ma_in;
         mt_ff  <= mt_in;
         k_ff   <= k_in;
         mal_ff <= mal_in;
         mrl_ff <= mrl_in;
         dt_ff  <= dt_in;
         irl_ff <= irl_in;
      end
   end

   always_comb begin
      cfg.target_velocity   = tv_ff;
      cfg.max_accel         = ma_ff;
      cfg.max_tension       = mt_ff;
      cfg.stiffness         = k_ff;
      cfg.min_actual_length = mal_ff;
      cfg.min_rest_length   = mrl_ff;
      cfg.time_step         = dt_ff;
   end

   lrla_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .ctrl      (ctrl)
   );

   lrla_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .req_data  (req_data),
      .cfg       (cfg),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
